[design/aesctr_pkg.sv]
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared types, constants and AES helper functions for the CTR keystream unit.
// ----------------------------------------------------------------------------
package aesctr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_KEY_LEN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY0    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY1    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY2    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_KEY3    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NONCE   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_START   = 3'd6;

  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  // item passed from the front to the back
  typedef struct packed {
    logic [7:0]  data;
    logic [59:0] blk;
    logic [3:0]  off;
  } item_t;

  // block request from back to AES engine
  typedef struct packed {
    logic        valid;
    logic [59:0] blk;
  } blk_req_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_KEXP  = 3'b010,
    ST_ROUND = 3'b100
  } eng_state_e;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // SubBytes, ShiftRows and (unless last) MixColumns; byte 0 in bits 127:120
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[4*c+i] = b[4*((c+i)%4)+i];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                             a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
      end
    end
    return r;
  endfunction

endpackage

[design/aes_counter_mode_keystream_xor_unit.sv]
// ----------------------------------------------------------------------------
// aes_counter_mode_keystream_xor_unit
// AES-CTR keystream XOR, one byte per beat.
// ----------------------------------------------------------------------------
// Input beats (data_byte_i, restart_i) enter on valid_i/ready_o and go into a
// four-entry queue; output beats leave on valid_o/ready_i through one register.
// restart_i loads the position from start_position before that byte.
// Bytes within a cached 16-byte keystream block pass at one per cycle while
// ready_i stays high, through a queue entry and then the output register.
// A new block (miss) stalls while a request goes to the single-round AES unit
// and it runs its Nr rounds (10/12/14); the first block after reset or a key
// or nonce change first waits for key expansion and a return to idle.
// Reset clears the position, the cached-block flag and both handshakes.
// When the receiver stalls, the output register holds, the queue fills and
// ready_o falls; configuration must be written only while idle (unchecked).
// ----------------------------------------------------------------------------
module aes_counter_mode_keystream_xor_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [aesctr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [aesctr_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [7:0]                         data_byte_i,
  input  logic                               restart_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  output logic [7:0]                         out_byte_o,
  output logic                               valid_o,
  input  logic                               ready_i
);

  logic [1:0]   key_len_q;
  logic [255:0] key_q;
  logic [63:0]  nonce_q, start_q;
  logic         dirty;
  aesctr_pkg::item_t    item;
  aesctr_pkg::blk_req_t req;
  logic item_valid, item_ready, eng_busy, eng_done;
  logic [127:0] eng_block;

  // key length, key words and nonce all invalidate the cached block
  assign dirty = cfg_we_i && (cfg_idx_i <= aesctr_pkg::CFG_NONCE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= '0;
      key_q     <= '0;
      nonce_q   <= '0;
      start_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aesctr_pkg::CFG_KEY_LEN: key_len_q <= cfg_data_i[1:0];
        aesctr_pkg::CFG_KEY0:    key_q[255:192] <= cfg_data_i;
        aesctr_pkg::CFG_KEY1:    key_q[191:128] <= cfg_data_i;
        aesctr_pkg::CFG_KEY2:    key_q[127:64]  <= cfg_data_i;
        aesctr_pkg::CFG_KEY3:    key_q[63:0]    <= cfg_data_i;
        aesctr_pkg::CFG_NONCE:   nonce_q <= cfg_data_i;
        aesctr_pkg::CFG_START:   start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aesctr_front u_front (
    .clk_i, .rst_ni, .start_pos_i(start_q), .data_byte_i, .restart_i, .valid_i,
    .ready_o, .item_o(item), .item_valid_o(item_valid), .item_ready_i(item_ready)
  );

  aesctr_engine u_engine (
    .clk_i, .rst_ni, .key_len_i(key_len_q), .key_i(key_q), .nonce_i(nonce_q),
    .key_dirty_i(dirty), .req_i(req), .busy_o(eng_busy), .done_o(eng_done),
    .block_o(eng_block)
  );

  aesctr_back u_back (
    .clk_i, .rst_ni, .key_dirty_i(dirty), .item_i(item), .item_valid_i(item_valid),
    .item_ready_o(item_ready), .req_o(req), .eng_busy_i(eng_busy),
    .eng_done_i(eng_done), .eng_block_i(eng_block), .out_byte_o, .valid_o, .ready_i
  );

`ifndef NO_ASSERTIONS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_done |-> eng_busy) else $error("done without busy");
  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_busy |-> !req.valid) else $error("request while engine busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o) else $error("output dropped");
`endif

endmodule

[design/aesctr_front.sv]
// ----------------------------------------------------------------------------
// aesctr_front
// Accepts bytes, tracks the stream position and queues (byte, block, offset).
// ----------------------------------------------------------------------------
module aesctr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [63:0]          start_pos_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 restart_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  output aesctr_pkg::item_t    item_o,
  output logic                 item_valid_o,
  input  logic                 item_ready_i
);

  logic [63:0] pos_q, pos_d, cur_pos;
  aesctr_pkg::item_t mem_q [aesctr_pkg::QDepth];
  logic [aesctr_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [aesctr_pkg::QPtrW:0]   cnt_q;
  logic push, pop;

  assign cur_pos  = restart_i ? start_pos_i : pos_q;
  assign ready_o  = (cnt_q != 3'(aesctr_pkg::QDepth));
  assign push     = valid_i & ready_o;
  assign item_valid_o = (cnt_q != '0);
  assign pop      = item_valid_o & item_ready_i;
  assign item_o   = mem_q[rd_q];
  assign pos_d    = cur_pos + 64'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        pos_q <= pos_d;
        wr_q  <= wr_q + 1'b1;
      end
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= '{data: data_byte_i, blk: cur_pos[63:4], off: cur_pos[3:0]};
  end

endmodule

[design/aesctr_engine.sv]
// ----------------------------------------------------------------------------
// aesctr_engine
// Iterative AES: on-the-fly key expansion into a word store, then one round
// per cycle. Re-expands after any key change.
// ----------------------------------------------------------------------------
module aesctr_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            key_len_i,
  input  logic [255:0]          key_i,
  input  logic [63:0]           nonce_i,
  input  logic                  key_dirty_i,
  input  aesctr_pkg::blk_req_t  req_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [127:0]          block_o
);

  aesctr_pkg::eng_state_e st_q, st_d;
  logic [127:0] rk_q [15];  // one round key per entry
  logic [31:0]  win_q [8];  // last eight expanded words
  logic [5:0]   wi_q;       // expansion word index
  logic [3:0]   cyc_q;      // wi mod nk
  logic [3:0]   rnd_q;
  logic [127:0] s_q;
  logic         kvalid_q;
  logic [7:0]   rcon_q;
  logic [3:0]   nk, nr;
  logic [5:0]   total;
  logic [31:0]  t, w_new, wm1, wmnk;
  logic [127:0] rk_blk, rk0;

  function automatic logic [31:0] sub_word_r(input logic [31:0] w);
    return aesctr_pkg::sub_word({w[23:0], w[31:24]});
  endfunction

  assign nk    = (key_len_i == aesctr_pkg::KEY_128) ? 4'd4 :
                 (key_len_i == aesctr_pkg::KEY_192) ? 4'd6 : 4'd8;
  assign nr    = nk + 4'd6;
  assign total = {nr, 2'b00} + 6'd4;

  // word i-1 and i-nk come from a shift of the last eight words
  assign wm1  = win_q[7];
  assign wmnk = win_q[3'(4'd8 - nk)];

  always_comb begin
    t = wm1;
    if (cyc_q == 4'd0) t = sub_word_r(t) ^ {rcon_q, 24'd0};
    else if (nk == 4'd8 && cyc_q == 4'd4) t = aesctr_pkg::sub_word(t);
    w_new = wmnk ^ t;
  end

  assign rk_blk = rk_q[rnd_q];
  assign rk0    = rk_q[0];

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      aesctr_pkg::ST_IDLE:  if (req_i.valid) st_d = (kvalid_q && !key_dirty_i) ?
                                 aesctr_pkg::ST_ROUND : aesctr_pkg::ST_KEXP;
      aesctr_pkg::ST_KEXP:  if (wi_q == total - 6'd1) st_d = aesctr_pkg::ST_IDLE;
      aesctr_pkg::ST_ROUND: if (rnd_q == nr) st_d = aesctr_pkg::ST_IDLE;
      default:              st_d = aesctr_pkg::ST_IDLE;
    endcase
  end

  assign busy_o  = (st_q != aesctr_pkg::ST_IDLE);
  assign done_o  = (st_q == aesctr_pkg::ST_ROUND) && (rnd_q == nr);
  assign block_o = aesctr_pkg::aes_round(s_q, 1'b1) ^ rk_blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= aesctr_pkg::ST_IDLE;
      kvalid_q <= 1'b0;
      wi_q     <= '0;
      rnd_q    <= '0;
      cyc_q    <= '0;
      rcon_q   <= 8'h01;
    end else begin
      st_q <= st_d;
      if (key_dirty_i) kvalid_q <= 1'b0;
      else if (st_q == aesctr_pkg::ST_KEXP && wi_q == total - 6'd1) kvalid_q <= 1'b1;
      unique case (st_q)
        aesctr_pkg::ST_IDLE: begin
          wi_q   <= 6'(nk);
          cyc_q  <= '0;
          rcon_q <= 8'h01;
          rnd_q  <= 4'd1;
        end
        aesctr_pkg::ST_KEXP: begin
          wi_q  <= wi_q + 6'd1;
          cyc_q <= (cyc_q == nk - 4'd1) ? 4'd0 : cyc_q + 4'd1;
          if (cyc_q == 4'd0) rcon_q <= aesctr_pkg::xtime(rcon_q);
        end
        aesctr_pkg::ST_ROUND: rnd_q <= rnd_q + 4'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == aesctr_pkg::ST_IDLE) begin
      for (int i = 0; i < 8; i++) begin
        // raw key words only; the words above nk hold the expansion
        if (i < 32'(nk)) rk_q[i >> 2][127-32*(i & 3) -: 32] <= key_i[255-32*i -: 32];
        win_q[i] <= (i >= 8 - 32'(nk)) ? key_i[255-32*(i-(8-32'(nk))) -: 32] : 32'd0;
      end
      s_q <= {nonce_i, 4'd0, req_i.blk} ^ rk0;
    end else if (st_q == aesctr_pkg::ST_KEXP) begin
      rk_q[wi_q[5:2]][127-32*wi_q[1:0] -: 32] <= w_new;
      for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
      win_q[7] <= w_new;
    end else if (st_q == aesctr_pkg::ST_ROUND) begin
      s_q <= aesctr_pkg::aes_round(s_q, 1'b0) ^ rk_blk;
    end
  end

endmodule

[design/aesctr_back.sv]
// ----------------------------------------------------------------------------
// aesctr_back
// Checks the cached keystream block, requests a new one on a miss and XORs.
// ----------------------------------------------------------------------------
module aesctr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  key_dirty_i,
  input  aesctr_pkg::item_t     item_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  output aesctr_pkg::blk_req_t  req_o,
  input  logic                  eng_busy_i,
  input  logic                  eng_done_i,
  input  logic [127:0]          eng_block_i,
  output logic [7:0]            out_byte_o,
  output logic                  valid_o,
  input  logic                  ready_i
);

  logic [127:0] ks_q;
  logic [59:0]  cblk_q;
  logic         have_q, out_v_q;
  logic [7:0]   out_q;
  logic         hit, slot_free;

  assign hit       = have_q && (cblk_q == item_i.blk);
  assign slot_free = !out_v_q || ready_i;
  assign item_ready_o = item_valid_i && hit && slot_free && !key_dirty_i;
  assign req_o.valid  = item_valid_i && !hit && !eng_busy_i && !key_dirty_i;
  assign req_o.blk    = item_i.blk;
  assign out_byte_o   = out_q;
  assign valid_o      = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      out_v_q <= 1'b0;
      cblk_q  <= '0;
    end else begin
      if (key_dirty_i) have_q <= 1'b0;
      else if (eng_done_i) begin
        have_q <= 1'b1;
        cblk_q <= item_i.blk;
      end
      if (item_ready_o) out_v_q <= 1'b1;
      else if (ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done_i) ks_q <= eng_block_i;
    if (item_ready_o) out_q <= item_i.data ^ ks_q[127 - 8*item_i.off -: 8];
  end

endmodule
